// ----- sv/kts_pkg.sv -----
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, constants and sequencer states of the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int KTS_MAX_KEYS  = 64;
    localparam int DIV_STEPS     = 40;

    localparam logic       KIND_APPEND = 1'b0;
    localparam logic       KIND_SAMPLE = 1'b1;

    localparam logic       CFG_CLIP_FRAMES = 1'b0;
    localparam logic       CFG_LOOP_ENABLE = 1'b1;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_INTERP  = 3'd2;
    localparam logic [2:0] ST_SINGLE  = 3'd3;
    localparam logic [2:0] ST_PAST    = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    typedef struct packed {
        logic        kind;
        logic [23:0] frame_time;
        logic [31:0] in_x;
        logic [31:0] in_y;
        logic [31:0] in_z;
    } t_in_req;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [2:0]  status;
    } t_out_rsp;

    typedef struct packed {
        logic [23:0] key_time;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } t_key;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FOLD,
        S_START,
        S_ONE,
        S_LAST,
        S_RD,
        S_CMP,
        S_DIV,
        S_MSET,
        S_MUL,
        S_SUM,
        S_DONE
    } t_state;

endpackage

// ----- sv/keyframe_track_sampler.sv -----
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe position track with linear interpolation on a shared serial unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_stall with payload i_in_req. An
//   append request stores one keyframe unless the track is full; a sample
//   request wraps or clamps the frame into the clip and blends the two keys
//   around it. Each request yields exactly one response on o_out_valid /
//   i_out_stall with payload o_out_rsp. The user writes registers clip_frames
//   and loop_enable on i_cfg_valid / o_cfg_ready only while the block is
//   idle; the block itself does not enforce it.
// Sequence:
//   Append: straight to the response register. Sample: wrap remainder (when
//   looping past the clip end), key scan (one RAM read per key), alpha
//   division, bit-serial blend per axis, then the response load. The key scan
//   and the serial divider/multiplier dominate a sample request. o_in_stall is
//   high from the accepting edge until the response is loaded.
// Reset: clears the key count, the sequencer and the registers to their
//   defaults; key RAM content is not cleared. A stalled response holds and
//   the sequencer waits to load the next one.
// ----------------------------------------------------------------------------
module keyframe_track_sampler
    import kts_pkg::*;
#(
    parameter int MAX_KEYS = KTS_MAX_KEYS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    t_state r_state, n_state;

    logic [15:0]   r_clip;
    logic          r_loop;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic [5:0]    r_cnt;
    logic [23:0]   r_f;
    logic [39:0]   r_dvd;
    logic [23:0]   r_rem;
    logic [23:0]   r_dsr;
    logic [39:0]   r_amag;
    logic          r_aneg;
    logic [72:0]   r_d;
    logic [72:0]   r_acc;
    logic [39:0]   r_mq;
    logic          r_neg;
    logic [1:0]    r_axis;
    t_key          r_prev;
    t_key          r_cur;
    logic [31:0]   r_res [3];
    logic [2:0]    r_status;
    logic          r_out_valid;
    t_out_rsp      r_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_key          ram_wdata;
    t_key          ram_rdata;
    logic          accept;
    logic          out_free;
    logic          full;
    logic [23:0]   clip_end;

    logic [24:0]   rem_sh;
    logic          rem_ge;
    logic [23:0]   rem_nx;

    logic [24:0]   num;
    logic [24:0]   den;
    logic [24:0]   num_mag;
    logic [24:0]   den_mag;
    logic [31:0]   p0;
    logic [31:0]   p1;
    logic [32:0]   diff;
    logic [32:0]   diff_mag;
    logic [56:0]   m_full;
    logic [33:0]   m_clamp;
    logic [35:0]   q;
    logic [35:0]   s;
    logic [31:0]   s_sat;

    kts_ram #(
        .WIDTH($bits(t_key)),
        .DEPTH(MAX_KEYS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign accept    = i_in_valid && i_rst_n && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign full      = (r_count >= CW'(MAX_KEYS));
    assign clip_end  = {((r_clip == 16'd0) ? 16'd1 : r_clip), 8'd0};
    assign ram_waddr = r_count[AW-1:0];
    assign ram_wdata = '{key_time: i_in_req.frame_time, pos_x: i_in_req.in_x,
                         pos_y: i_in_req.in_y, pos_z: i_in_req.in_z};

    assign rem_sh = {r_rem, r_dvd[39]};
    assign rem_ge = (rem_sh >= {1'b0, r_dsr});
    assign rem_nx = rem_ge ? 24'(rem_sh - {1'b0, r_dsr}) : rem_sh[23:0];

    assign num     = {1'b0, r_f} - {1'b0, r_prev.key_time};
    assign den     = {1'b0, ram_rdata.key_time} - {1'b0, r_prev.key_time};
    assign num_mag = num[24] ? -num : num;
    assign den_mag = den[24] ? -den : den;

    always_comb begin
        unique case (r_axis)
            2'd0:    begin p0 = r_prev.pos_x; p1 = r_cur.pos_x; end
            2'd1:    begin p0 = r_prev.pos_y; p1 = r_cur.pos_y; end
            default: begin p0 = r_prev.pos_z; p1 = r_cur.pos_z; end
        endcase
    end

    assign diff     = {p1[31], p1} - {p0[31], p0};
    assign diff_mag = diff[32] ? -diff : diff;
    assign m_full   = r_acc[72:16];
    assign m_clamp  = (|m_full[56:33]) ? {1'b1, 33'd0} : {1'b0, m_full[32:0]};
    assign q        = r_neg ? -{2'b00, m_clamp} : {2'b00, m_clamp};
    assign s        = {{4{p0[31]}}, p0} + q;

    always_comb begin
        if (!s[35] && (|s[34:31])) begin
            s_sat = 32'h7FFF_FFFF;
        end else if (s[35] && !(&s[34:31])) begin
            s_sat = 32'h8000_0000;
        end else begin
            s_sat = s[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_req.kind == KIND_APPEND) begin
                        n_state = S_DONE;
                    end else if (i_in_req.frame_time > clip_end && r_loop) begin
                        n_state = S_FOLD;
                    end else begin
                        n_state = S_START;
                    end
                end
            end
            S_FOLD:  if (r_cnt == 6'(DIV_STEPS - 1)) n_state = S_START;
            S_START: begin
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else if (r_count == CW'(1)) begin
                    n_state = S_ONE;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_ONE:   n_state = S_DONE;
            S_LAST:  n_state = (r_f > ram_rdata.key_time) ? S_DONE : S_RD;
            S_RD:    n_state = S_CMP;
            S_CMP: begin
                if (r_idx != '0 && ram_rdata.key_time > r_f) begin
                    n_state = (den == '0) ? S_MSET : S_DIV;
                end else if (CW'(r_idx) == CW'(r_count - CW'(1))) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DIV:   if (r_cnt == 6'(DIV_STEPS - 1)) n_state = S_MSET;
            S_MSET:  n_state = S_MUL;
            S_MUL:   if (r_cnt == 6'(DIV_STEPS - 1)) n_state = S_SUM;
            S_SUM:   n_state = (r_axis == 2'd2) ? S_DONE : S_MSET;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = !i_rst_n || (r_state != S_IDLE);
        ram_we     = accept && (i_in_req.kind == KIND_APPEND) && !full;
        unique case (r_state)
            S_START: ram_raddr = (r_count == CW'(1)) ? '0
                                                     : AW'(r_count - CW'(1));
            default: ram_raddr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clip      <= 16'd1;
            r_loop      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CLIP_FRAMES: r_clip <= i_cfg_data;
                    CFG_LOOP_ENABLE: r_loop <= i_cfg_data[0];
                endcase
            end
            if (ram_we) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_res[0] <= '0;
                r_res[1] <= '0;
                r_res[2] <= '0;
                r_cnt    <= '0;
                r_idx    <= '0;
                r_axis   <= '0;
                r_f      <= (i_in_req.frame_time > clip_end) ? clip_end - 24'd256
                                                             : i_in_req.frame_time;
                r_status <= full ? ST_FULL : ST_STORED;
                r_dvd <= {16'd0, i_in_req.frame_time - 24'd1};
                r_rem <= '0;
                r_dsr <= clip_end;
            end
            S_FOLD: begin
                r_dvd <= {r_dvd[38:0], rem_ge};
                r_rem <= rem_nx;
                r_cnt <= r_cnt + 6'd1;
                r_f   <= rem_nx + 24'd1;
            end
            S_START: begin
                r_cnt    <= '0;
                r_status <= (r_count == '0) ? ST_EMPTY : ST_SINGLE;
            end
            S_ONE: begin
                r_res[0] <= ram_rdata.pos_x;
                r_res[1] <= ram_rdata.pos_y;
                r_res[2] <= ram_rdata.pos_z;
            end
            S_LAST: begin
                r_status <= (r_f > ram_rdata.key_time) ? ST_PAST : ST_INTERP;
            end
            S_RD: begin
            end
            S_CMP: begin
                r_cur  <= ram_rdata;
                r_dvd  <= {num_mag[23:0], 16'd0};
                r_rem  <= '0;
                r_dsr  <= den_mag[23:0];
                r_aneg <= (den == '0) ? 1'b0 : (num[24] ^ den[24]);
                r_amag <= '0;
                r_cnt  <= '0;
                if (!(r_idx != '0 && ram_rdata.key_time > r_f)) begin
                    r_prev   <= ram_rdata;
                    r_idx    <= r_idx + AW'(1);
                    r_res[0] <= ram_rdata.pos_x;
                    r_res[1] <= ram_rdata.pos_y;
                    r_res[2] <= ram_rdata.pos_z;
                end
            end
            S_DIV: begin
                r_dvd  <= {r_dvd[38:0], rem_ge};
                r_rem  <= rem_nx;
                r_cnt  <= r_cnt + 6'd1;
                r_amag <= {r_dvd[38:0], rem_ge};
            end
            S_MSET: begin
                r_d   <= {40'd0, diff_mag};
                r_neg <= r_aneg ^ diff[32];
                r_acc <= '0;
                r_mq  <= r_amag;
                r_cnt <= '0;
            end
            S_MUL: begin
                if (r_mq[0]) begin
                    r_acc <= r_acc + r_d;
                end
                r_d   <= {r_d[71:0], 1'b0};
                r_mq  <= {1'b0, r_mq[39:1]};
                r_cnt <= r_cnt + 6'd1;
            end
            S_SUM: begin
                r_res[r_axis] <= s_sat;
                r_axis        <= r_axis + 2'd1;
            end
            S_DONE: begin
                if (out_free) begin
                    r_out <= '{out_x: r_res[0], out_y: r_res[1],
                               out_z: r_res[2], status: r_status};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = i_rst_n;

endmodule

// ----- sv/kts_ram.sv -----
// ----------------------------------------------------------------------------
// kts_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module kts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/kts_checker.sv -----
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks on the keyframe track sampler, bound to the top level.
// ----------------------------------------------------------------------------
module kts_checker
    import kts_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_in_req  i_in_req,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_rsp o_out_rsp
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted request did not make the block busy");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_rsp)))
        else $error("stalled response changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.status <= ST_EMPTY))
        else $error("response status out of range");

    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status != ST_INTERP && o_out_rsp.status != ST_SINGLE)
        |-> (o_out_rsp.out_x == '0 && o_out_rsp.out_y == '0 && o_out_rsp.out_z == '0))
        else $error("nonzero position on a response without a sample");

endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (.*);
